>>> rtl/lire_pkg.sv
// Shared constants, types and weight tables of the loss interval rate estimator.
// Used by the controller, the datapath and the top level. No dependencies.
package lire_pkg;

  // History size and derived storage sizes.
  localparam int HISTORY = 8;
  localparam int DEPTH   = HISTORY + 2;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);

  // Field and accumulator widths.
  localparam int LEN_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int CNT_W   = 5;
  localparam int REG_W   = 2;
  localparam int DEN_W   = FRAC_W + $clog2(DEPTH);
  localparam int SUM_W   = DEN_W + LEN_W;
  localparam int PROD_W  = SUM_W + DEN_W;
  localparam int DIV_W   = SUM_W + 1;
  localparam int ESH     = 2 * (FRAC_W - 1);
  localparam int RATIO_SHIFT = LEN_W - (FRAC_W - 1);
  localparam int DCNT_W  = $clog2(LEN_W + 1);
  localparam int MCNT_W  = $clog2(DEN_W + 1);

  localparam logic [FRAC_W-1:0] ONE     = FRAC_W'(1) << (FRAC_W - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX = '1;

  // Weight table geometry for both history modes.
  localparam int MID0  = HISTORY / 2;
  localparam int MID1  = (HISTORY + 1) / 2;
  localparam int Wdiv0 = MID0 + 1;
  localparam int Wdiv1 = MID1 + 1;

  typedef enum logic [REG_W-1:0] {
    REG_SMOOTH    = 2'd0,
    REG_DISCOUNT  = 2'd1,
    REG_MIN_RATIO = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {PASS_A, PASS_1, PASS_2} pass_e;
  typedef enum logic [1:0] {DIV_RATIO, DIV_AVG, DIV_RATE} div_e;
  typedef enum logic {XM_N2D1, XM_N1D2} xmul_e;
  typedef enum logic [2:0] {
    RES_NONE, RES_ZERO, RES_SAT, RES_AVG_MAX, RES_AVG_Q, RES_RATE_MAX, RES_RATE_Q
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          scale_en;
    logic [AW-1:0] scale_idx;
    logic          scale_done;
    logic          issue;
    pass_e         pass;
    logic [AW-1:0] idx;
    logic          acc_clr;
    logic          rhs_load;
    logic          div_start;
    div_e          div_mode;
    logic          df_load;
    logic          xmul_start;
    xmul_e         xmul_sel;
    logic          sel_load;
    res_e          res_op;
    logic          out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             lost;
    logic             report;
    logic [CNT_W-1:0] count;
    logic             smooth;
    logic             disc_en;
    logic             len0_nz;
    logic             lhs_lt_rhs;
    logic             div_busy;
    logic             mul_busy;
    logic             cn_zero;
    logic             avg_ovf;
    logic             rate_ovf;
  } status_t;

  // Interval weights of one history mode, packed entry 0 in the low bits.
  function automatic logic [DEPTH*FRAC_W-1:0] weight_row(input logic smooth);
    int mid;
    int d;
    int num;
    logic [DEPTH*FRAC_W-1:0] row;
    row = '0;
    mid = smooth ? MID1 : MID0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i < mid) begin
        row[i*FRAC_W +: FRAC_W] = ONE;
      end else begin
        d   = smooth ? (i - mid) : (i + 1 - mid);
        num = (mid + 1 > d) ? (mid + 1 - d) : 0;
        if (smooth) begin
          row[i*FRAC_W +: FRAC_W] = FRAC_W'((num * int'(ONE)) / Wdiv1);
        end else begin
          row[i*FRAC_W +: FRAC_W] = FRAC_W'((num * int'(ONE)) / Wdiv0);
        end
      end
    end
    return row;
  endfunction

  localparam logic [DEPTH*FRAC_W-1:0] W_ROW0 = weight_row(1'b0);
  localparam logic [DEPTH*FRAC_W-1:0] W_ROW1 = weight_row(1'b1);

endpackage

>>> rtl/lire_datapath.sv
// Datapath of the loss interval rate estimator: history, weighted sums,
// serial divider and multiplier, result registers. Depends on lire_pkg.
module lire_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lire_pkg::REG_W-1:0]  cfg_index_i,
  input  logic [lire_pkg::FRAC_W-1:0] cfg_data_i,
  input  logic                        in_accept_i,
  input  logic                        packet_lost_i,
  input  logic                        report_i,
  input  lire_pkg::cmd_t              cmd_i,
  output lire_pkg::status_t           status_o,
  output logic [lire_pkg::LEN_W-1:0]  loss_event_rate_o,
  output logic [lire_pkg::LEN_W-1:0]  average_interval_o,
  output logic                        saturated_o
);
  import lire_pkg::*;

  // Configuration and history state.
  logic              smooth_q, disc_q;
  logic [FRAC_W-1:0] minr_q;
  logic [LEN_W-1:0]  len_q  [DEPTH];
  logic [FRAC_W-1:0] mult_q [DEPTH];
  logic [FRAC_W-1:0] df_q;
  logic [CNT_W-1:0]  count_q;
  logic              lost_q, report_q;

  // Weighted sum pipeline.
  logic                v1_q, v2_q, k1_q, k2_q;
  logic [2*FRAC_W-1:0] p1_q;
  logic [FRAC_W-1:0]   g1_q, e2_q;
  logic [LEN_W-1:0]    len1_q, len2_q;
  logic [SUM_W-1:0]    num_q [2];
  logic [DEN_W-1:0]    den_q [2];

  // Discount compare, divider, multiplier and selection.
  logic [DIV_W-1:0]  lhs_q, rhs_q, rem_q, dvs_q;
  logic [LEN_W-1:0]  low_q, quo_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              div_busy_q;
  logic [PROD_W-1:0] ma_q, mp_q;
  logic [DEN_W-1:0]  mb_q;
  logic [MCNT_W-1:0] mcnt_q;
  logic              mul_busy_q;
  xmul_e             msel_q;
  logic [PROD_W-1:0] x_q [2];
  logic [SUM_W-1:0]  cn_q;
  logic [DEN_W-1:0]  cd_q;

  // Result working and output registers.
  logic [LEN_W-1:0] rate_w_q, avg_w_q, rate_o_q, avg_o_q;
  logic             sat_w_q, sat_o_q;

  logic [LEN_W-1:0]        len0_inc;
  logic [DEPTH*FRAC_W-1:0] wrow;
  logic [AW-1:0]           widx;
  logic [FRAC_W-1:0]       wsel, gsel;
  logic [2*FRAC_W-1:0]     scale_prod;
  logic [3*FRAC_W-1:0]     e_prod;
  logic [DIV_W:0]          div_t;
  logic                    div_ge;
  logic [PROD_W-1:0]       mp_next;
  logic [SUM_W-1:0]        n1e, n2e;
  logic                    choose2;
  logic [FRAC_W-1:0]       ratio, minr;

  // Combinational helpers.
  always_comb begin
    len0_inc   = (len_q[0] != LEN_MAX) ? len_q[0] + LEN_W'(1) : len_q[0];
    wrow       = smooth_q ? W_ROW1 : W_ROW0;
    widx       = cmd_i.idx + AW'((cmd_i.pass == PASS_1) && smooth_q);
    wsel       = wrow[widx*FRAC_W +: FRAC_W];
    gsel       = ((cmd_i.pass == PASS_A) || (cmd_i.idx == '0)) ? ONE : df_q;
    scale_prod = mult_q[cmd_i.scale_idx - AW'(1)] * df_q;
    e_prod     = p1_q * g1_q;
    div_t      = {rem_q, low_q[LEN_W-1]};
    div_ge     = div_t >= {1'b0, dvs_q};
    mp_next    = mb_q[0] ? mp_q + ma_q : mp_q;
    n1e        = (den_q[0] == '0) ? '0 : num_q[0];
    n2e        = (den_q[1] == '0) ? '0 : num_q[1];
    choose2    = (n2e != '0) && ((n1e == '0) || (x_q[0] > x_q[1]));
    ratio      = FRAC_W'(quo_q >> RATIO_SHIFT);
    minr       = {1'b0, minr_q[FRAC_W-1:1]};
  end

  // Configuration, history and discount factor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 1'b0;
      disc_q   <= 1'b1;
      minr_q   <= ONE;
      df_q     <= ONE;
      count_q  <= CNT_W'(1);
      lost_q   <= 1'b0;
      report_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        len_q[i]  <= '0;
        mult_q[i] <= ONE;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SMOOTH:    smooth_q <= cfg_data_i[0];
          REG_DISCOUNT:  disc_q   <= cfg_data_i[0];
          REG_MIN_RATIO: minr_q   <= cfg_data_i;
          default:       ;
        endcase
      end
      if (in_accept_i) begin
        lost_q   <= packet_lost_i;
        report_q <= report_i;
        if (packet_lost_i) begin
          if (count_q != CNT_MAX) count_q <= count_q + CNT_W'(1);
          len_q[0] <= '0;
          len_q[1] <= len0_inc;
          for (int i = 2; i < DEPTH; i++) len_q[i] <= len_q[i-1];
        end else begin
          len_q[0] <= len0_inc;
        end
      end
      // Multipliers shift one place per step, scaled by the discount factor.
      if (cmd_i.scale_en) begin
        mult_q[cmd_i.scale_idx] <= scale_prod[FRAC_W-1 +: FRAC_W];
      end
      if (cmd_i.scale_done) begin
        mult_q[1] <= ONE;
        df_q      <= ONE;
      end
      if (cmd_i.df_load) df_q <= (ratio < minr) ? minr : ratio;
    end
  end

  // Pipeline valid bits and unit busy flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      div_busy_q <= 1'b0;
      mul_busy_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
      end else if (div_busy_q && dcnt_q == DCNT_W'(1)) begin
        div_busy_q <= 1'b0;
      end
      if (cmd_i.xmul_start) begin
        mul_busy_q <= 1'b1;
      end else if (mul_busy_q && mcnt_q == MCNT_W'(1)) begin
        mul_busy_q <= 1'b0;
      end
    end
  end

  // Weighted sum stages: weight product, gain product, accumulate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      p1_q   <= mult_q[cmd_i.idx] * wsel;
      g1_q   <= gsel;
      len1_q <= len_q[cmd_i.idx];
      k1_q   <= (cmd_i.pass == PASS_2);
    end
    e2_q   <= e_prod[ESH +: FRAC_W];
    len2_q <= len1_q;
    k2_q   <= k1_q;
    if (cmd_i.acc_clr) begin
      num_q[cmd_i.pass == PASS_2] <= '0;
      den_q[cmd_i.pass == PASS_2] <= '0;
    end else if (v2_q) begin
      num_q[k2_q] <= num_q[k2_q] + SUM_W'(e2_q * len2_q);
      den_q[k2_q] <= den_q[k2_q] + DEN_W'(e2_q);
    end
    if (cmd_i.rhs_load) begin
      lhs_q <= {num_q[0], 1'b0};
      rhs_q <= DIV_W'(len_q[0] * den_q[0]);
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dcnt_q <= DCNT_W'(LEN_W);
      case (cmd_i.div_mode)
        DIV_RATIO: begin
          rem_q <= lhs_q;
          dvs_q <= rhs_q;
          low_q <= '0;
        end
        DIV_AVG: begin
          rem_q <= DIV_W'(cn_q[SUM_W-1:LEN_W]);
          dvs_q <= DIV_W'(cd_q);
          low_q <= cn_q[LEN_W-1:0];
        end
        default: begin
          rem_q <= DIV_W'(cd_q);
          dvs_q <= DIV_W'(cn_q);
          low_q <= '0;
        end
      endcase
    end else if (div_busy_q) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
      low_q  <= low_q << 1;
      quo_q  <= {quo_q[LEN_W-2:0], div_ge};
      rem_q  <= div_ge ? DIV_W'(div_t - {1'b0, dvs_q}) : div_t[DIV_W-1:0];
    end
  end

  // Shift-and-add multiplier for the cross products of the two averages.
  always_ff @(posedge clk_i) begin
    if (cmd_i.xmul_start) begin
      mcnt_q <= MCNT_W'(DEN_W);
      msel_q <= cmd_i.xmul_sel;
      mp_q   <= '0;
      ma_q   <= (cmd_i.xmul_sel == XM_N2D1) ? PROD_W'(n2e) : PROD_W'(n1e);
      mb_q   <= (cmd_i.xmul_sel == XM_N2D1) ? den_q[0] : den_q[1];
    end else if (mul_busy_q) begin
      mcnt_q <= mcnt_q - MCNT_W'(1);
      mp_q   <= mp_next;
      ma_q   <= ma_q << 1;
      mb_q   <= mb_q >> 1;
      if (mcnt_q == MCNT_W'(1)) x_q[msel_q == XM_N1D2] <= mp_next;
    end
    if (cmd_i.sel_load) begin
      cn_q <= choose2 ? n2e : n1e;
      cd_q <= choose2 ? den_q[1] : den_q[0];
    end
  end

  // Result fields and the output register.
  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      RES_ZERO: begin
        rate_w_q <= '0;
        avg_w_q  <= '0;
        sat_w_q  <= 1'b0;
      end
      RES_SAT: begin
        rate_w_q <= LEN_MAX;
        avg_w_q  <= '0;
        sat_w_q  <= 1'b1;
      end
      RES_AVG_MAX: begin
        avg_w_q <= LEN_MAX;
        sat_w_q <= 1'b0;
      end
      RES_AVG_Q: begin
        avg_w_q <= quo_q;
        sat_w_q <= 1'b0;
      end
      RES_RATE_MAX: rate_w_q <= LEN_MAX;
      RES_RATE_Q:   rate_w_q <= quo_q;
      default:      ;
    endcase
    if (cmd_i.out_load) begin
      rate_o_q <= rate_w_q;
      avg_o_q  <= avg_w_q;
      sat_o_q  <= sat_w_q;
    end
  end

  always_comb begin
    status_o.lost       = lost_q;
    status_o.report     = report_q;
    status_o.count      = count_q;
    status_o.smooth     = smooth_q;
    status_o.disc_en    = disc_q;
    status_o.len0_nz    = (len_q[0] != '0);
    status_o.lhs_lt_rhs = lhs_q < rhs_q;
    status_o.div_busy   = div_busy_q;
    status_o.mul_busy   = mul_busy_q;
    status_o.cn_zero    = (cn_q == '0);
    status_o.avg_ovf    = cn_q[SUM_W-1:LEN_W] >= cd_q;
    status_o.rate_ovf   = SUM_W'(cd_q) >= cn_q;
  end

  assign loss_event_rate_o  = rate_o_q;
  assign average_interval_o = avg_o_q;
  assign saturated_o        = sat_o_q;

endmodule

>>> rtl/lire_controller.sv
// Controller of the loss interval rate estimator: sequences the history
// update, the weighted sum passes, the divisions and the output beat. Uses lire_pkg.
module lire_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lire_pkg::status_t status_i,
  output lire_pkg::cmd_t    cmd_o
);
  import lire_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ROUTE, S_SCALE, S_SCALE_END, S_REPORT, S_PASS, S_DRAIN, S_RHS, S_DCMP,
    S_DWAIT_R, S_XM1, S_XW1, S_XW2, S_SEL, S_DEC, S_DWAIT_A, S_RATE, S_DWAIT_T, S_OUT
  } state_e;

  state_e        state_q;
  pass_e         pass_q;
  logic [CW-1:0] idx_q, end_q, ds_q;
  logic [1:0]    drain_q;
  logic          first_q, out_valid_q;
  logic [CNT_W-1:0] np1, ds;
  logic [CW-1:0]    end1;
  logic             out_free;

  always_comb begin
    np1      = CNT_W'(HISTORY + 1) + CNT_W'(status_i.smooth);
    ds       = (status_i.count > np1) ? np1 : status_i.count;
    end1     = (status_i.smooth && ds_q == CW'(HISTORY + 2)) ? ds_q - CW'(1) : ds_q;
    out_free = !out_valid_q || !out_stall_i;
  end

  // State, loop counters and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= PASS_A;
      idx_q       <= '0;
      end_q       <= '0;
      ds_q        <= '0;
      drain_q     <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_ROUTE;
        S_ROUTE: begin
          idx_q   <= CW'(DEPTH - 1);
          state_q <= status_i.lost ? S_SCALE : S_REPORT;
        end
        S_SCALE: begin
          idx_q <= idx_q - CW'(1);
          if (idx_q == CW'(2)) state_q <= S_SCALE_END;
        end
        S_SCALE_END: state_q <= S_REPORT;
        S_REPORT: begin
          ds_q <= CW'(ds);
          if (!status_i.report) begin
            state_q <= S_IDLE;
          end else if (status_i.count <= CNT_W'(1)) begin
            state_q <= S_OUT;
          end else if (status_i.disc_en && status_i.len0_nz) begin
            pass_q  <= PASS_A;
            idx_q   <= CW'(1);
            end_q   <= CW'(ds);
            first_q <= 1'b1;
            state_q <= S_PASS;
          end else begin
            pass_q  <= PASS_1;
            idx_q   <= '0;
            end_q   <= (status_i.smooth && ds == CNT_W'(HISTORY + 2)) ? CW'(ds) - CW'(1)
                                                                       : CW'(ds);
            first_q <= 1'b1;
            state_q <= S_PASS;
          end
        end
        S_PASS: begin
          first_q <= 1'b0;
          idx_q   <= idx_q + CW'(1);
          if (idx_q + CW'(1) == end_q) begin
            drain_q <= '0;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_q <= drain_q + 2'd1;
          if (drain_q == 2'd2) begin
            case (pass_q)
              PASS_A: state_q <= S_RHS;
              PASS_1: begin
                pass_q  <= PASS_2;
                idx_q   <= CW'(1);
                end_q   <= ds_q;
                first_q <= 1'b1;
                state_q <= S_PASS;
              end
              default: state_q <= S_XM1;
            endcase
          end
        end
        S_RHS: state_q <= S_DCMP;
        S_DCMP, S_DWAIT_R: begin
          if (state_q == S_DCMP && status_i.lhs_lt_rhs) begin
            state_q <= S_DWAIT_R;
          end else if (state_q == S_DCMP || !status_i.div_busy) begin
            pass_q  <= PASS_1;
            idx_q   <= '0;
            end_q   <= end1;
            first_q <= 1'b1;
            state_q <= S_PASS;
          end
        end
        S_XM1: state_q <= S_XW1;
        S_XW1: if (!status_i.mul_busy) state_q <= S_XW2;
        S_XW2: if (!status_i.mul_busy) state_q <= S_SEL;
        S_SEL: state_q <= S_DEC;
        S_DEC: begin
          if (status_i.cn_zero) state_q <= S_OUT;
          else if (status_i.avg_ovf) state_q <= S_RATE;
          else state_q <= S_DWAIT_A;
        end
        S_DWAIT_A: if (!status_i.div_busy) state_q <= S_RATE;
        S_RATE: state_q <= status_i.rate_ovf ? S_OUT : S_DWAIT_T;
        S_DWAIT_T: if (!status_i.div_busy) state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd_o            = '0;
    cmd_o.pass       = pass_q;
    cmd_o.idx        = idx_q[AW-1:0];
    cmd_o.scale_idx  = idx_q[AW-1:0];
    cmd_o.div_mode   = DIV_RATIO;
    cmd_o.xmul_sel   = XM_N2D1;
    cmd_o.res_op     = RES_NONE;
    case (state_q)
      S_SCALE:     cmd_o.scale_en   = 1'b1;
      S_SCALE_END: cmd_o.scale_done = 1'b1;
      S_REPORT: begin
        if (status_i.report && status_i.count <= CNT_W'(1)) cmd_o.res_op = RES_ZERO;
      end
      S_PASS: begin
        cmd_o.issue   = 1'b1;
        cmd_o.acc_clr = first_q;
      end
      S_RHS: cmd_o.rhs_load = 1'b1;
      S_DCMP: cmd_o.div_start = status_i.lhs_lt_rhs;
      S_DWAIT_R: cmd_o.df_load = !status_i.div_busy;
      S_XM1: cmd_o.xmul_start = 1'b1;
      S_XW1: begin
        cmd_o.xmul_start = !status_i.mul_busy;
        cmd_o.xmul_sel   = XM_N1D2;
      end
      S_SEL: cmd_o.sel_load = 1'b1;
      S_DEC: begin
        cmd_o.div_mode = DIV_AVG;
        if (status_i.cn_zero) cmd_o.res_op = RES_SAT;
        else if (status_i.avg_ovf) cmd_o.res_op = RES_AVG_MAX;
        else cmd_o.div_start = 1'b1;
      end
      S_DWAIT_A: if (!status_i.div_busy) cmd_o.res_op = RES_AVG_Q;
      S_RATE: begin
        cmd_o.div_mode = DIV_RATE;
        if (status_i.rate_ovf) cmd_o.res_op = RES_RATE_MAX;
        else cmd_o.div_start = 1'b1;
      end
      S_DWAIT_T: if (!status_i.div_busy) cmd_o.res_op = RES_RATE_Q;
      S_OUT: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/loss_interval_rate_estimator_top.sv
// Loss interval rate estimator: one packet outcome per input beat, one loss
// event rate estimate per report. Uses lire_pkg, lire_controller and lire_datapath.
//
// Input channel: in_valid_i / in_stall_o carry packet_lost_i and report_i.
// A beat is taken when valid is high and stall is low. Output channel:
// out_valid_o / out_stall_i carry loss_event_rate_o (Q0.24),
// average_interval_o and saturated_o; one output beat per input beat with
// report set. Configuration is a plain write port (cfg_we_i, cfg_index_i,
// cfg_data_i), to be written only while the block is idle; the block does not enforce it.
// Per packet: a received packet without report passes S_ROUTE and S_REPORT.
// A loss adds the multiplier shift walk. A report adds up to three weighted
// sum passes of one history entry per cycle, up to three 24-step serial
// divisions and up to two 20-step serial multiplications, plus any wait on
// a stalled output beat.
// After reset the history is empty, the discount factor is 1.0 and reports
// give zero until the first loss. A stalled output beat stays in the output
// register; the next input beat is still taken and its result waits.
module loss_interval_rate_estimator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lire_pkg::REG_W-1:0]  cfg_index_i,
  input  logic [lire_pkg::FRAC_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        packet_lost_i,
  input  logic                        report_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lire_pkg::LEN_W-1:0]  loss_event_rate_o,
  output logic [lire_pkg::LEN_W-1:0]  average_interval_o,
  output logic                        saturated_o
);
  import lire_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  lire_controller u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .status_i (status),
    .cmd_o    (cmd)
  );

  lire_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_accept_i (in_accept),
    .packet_lost_i,
    .report_i,
    .cmd_i       (cmd),
    .status_o    (status),
    .loss_event_rate_o,
    .average_interval_o,
    .saturated_o
  );

endmodule

>>> rtl/lire_checker.sv
// Port-level checks of the loss interval rate estimator, bound to the top level.
// Depends on lire_pkg.
module lire_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lire_pkg::LEN_W-1:0]  loss_event_rate_o,
  input logic [lire_pkg::LEN_W-1:0]  average_interval_o,
  input logic                        saturated_o
);
  import lire_pkg::*;

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(loss_event_rate_o) &&
    $stable(average_interval_o) && $stable(saturated_o))
    else $error("output beat changed while stalled");

  // An accepted input beat keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // A saturated beat carries the full-scale rate and a zero average.
  a_sat_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> loss_event_rate_o == LEN_MAX &&
    average_interval_o == '0)
    else $error("saturated beat with wrong fields");

  // Below one packet the rate is either zero (no loss yet) or full scale.
  a_short_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !saturated_o && average_interval_o == '0 |->
    loss_event_rate_o == '0 || loss_event_rate_o == LEN_MAX)
    else $error("rate inconsistent with zero average");

endmodule

bind loss_interval_rate_estimator_top lire_checker u_lire_checker (.*);

>>> tb/loss_interval_rate_estimator_top_tb.sv
// Testbench of the loss interval rate estimator top level: directed and random
// packet outcomes, a built-in estimator model and a field by field result check.
// Depends on lire_pkg and loss_interval_rate_estimator_top.
module loss_interval_rate_estimator_top_tb;
  import lire_pkg::*;

  localparam int NDEPTH = HISTORY + 2;
  localparam logic [23:0] LMAX = 24'hFFFFFF;

  typedef struct packed {
    logic lost;
    logic report;
  } packet_t;

  typedef struct packed {
    logic [23:0] rate;
    logic [23:0] avg;
    logic        sat;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [REG_W-1:0] cfg_index_i = '0;
  logic [FRAC_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic packet_lost_i = 1'b0;
  logic report_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [LEN_W-1:0] loss_event_rate_o;
  logic [LEN_W-1:0] average_interval_o;
  logic saturated_o;

  loss_interval_rate_estimator_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // Estimator state mirrored in the testbench.
  logic        m_smooth;
  logic        m_disc_en;
  logic [15:0] m_min_ratio;
  logic [23:0] m_len [NDEPTH];
  logic [31:0] m_mult [NDEPTH];
  logic [31:0] m_wt [NDEPTH];
  logic [31:0] m_df;
  int          m_count;

  packet_t   pending_packets[$];
  estimate_t expected_estimates[$];
  int        mismatches = 0;
  int        accepted = 0;

  function automatic int hist_size();
    return HISTORY + int'(m_smooth);
  endfunction

  function automatic void rebuild_weights();
    int mid;
    int d;
    int num;
    mid = hist_size() / 2;
    for (int i = 0; i < NDEPTH; i++) begin
      if (i < mid) begin
        m_wt[i] = 32'd32768;
      end else begin
        d = m_smooth ? i - mid : i + 1 - mid;
        num = (mid + 1 > d) ? mid + 1 - d : 0;
        m_wt[i] = (num * 32768) / (mid + 1);
      end
    end
  endfunction

  function automatic void model_reset();
    m_smooth = 1'b0;
    m_disc_en = 1'b1;
    m_min_ratio = 16'd32768;
    for (int i = 0; i < NDEPTH; i++) begin
      m_len[i] = '0;
      m_mult[i] = 32'd32768;
    end
    m_df = 32'd32768;
    m_count = 1;
    rebuild_weights();
  endfunction

  // Weighted sum over entries lo..hi-1 as an exact numerator and denominator.
  function automatic void weighted_sum(input int lo, input int hi, input logic [31:0] f,
                                       output logic [127:0] num, output logic [127:0] den);
    int off;
    logic [127:0] e;
    off = 0;
    num = '0;
    den = '0;
    if (m_smooth && lo == 0) begin
      if (hi == hist_size() + 1) hi = hist_size();
      off = 1;
    end
    if (hi > NDEPTH - off) hi = NDEPTH - off;
    for (int i = lo; i < hi; i++) begin
      e = (128'(m_mult[i]) * m_wt[i + off] * ((i == 0) ? 32'd32768 : f)) >> 30;
      den += e;
      num += e * m_len[i];
    end
  endfunction

  // Advance the model by one packet; returns 1 with an estimate on a report.
  function automatic bit estimate_step(input packet_t p, output estimate_t r);
    int ds;
    logic [127:0] an, ad, lhs, rhs, n1, d1, n2, d2, cn, cd, q;
    logic [31:0] ratio, minr;
    r = '0;
    if (m_len[0] < LMAX) m_len[0]++;
    if (p.lost) begin
      if (m_count < 31) m_count++;
      for (int i = 1; i < NDEPTH; i++) m_mult[i] = (64'(m_mult[i]) * m_df) >> 15;
      for (int i = NDEPTH - 1; i > 0; i--) begin
        m_len[i] = m_len[i - 1];
        m_mult[i] = m_mult[i - 1];
      end
      m_len[0] = '0;
      m_mult[0] = 32'd32768;
      m_df = 32'd32768;
    end
    if (!p.report) return 0;
    if (m_count <= 1) return 1;
    ds = (m_count > hist_size() + 1) ? hist_size() + 1 : m_count;
    if (m_disc_en && m_len[0] > 0) begin
      weighted_sum(1, ds, 32'd32768, an, ad);
      lhs = 2 * an;
      rhs = m_len[0] * ad;
      if (lhs < rhs) begin
        ratio = 32'((lhs << 15) / rhs);
        minr = 32'(m_min_ratio >> 1);
        m_df = (ratio < minr) ? minr : ratio;
      end
    end
    weighted_sum(0, ds, m_df, n1, d1);
    weighted_sum(1, ds, m_df, n2, d2);
    if (d1 == 0) n1 = 0;
    if (d2 == 0) n2 = 0;
    if (n2 != 0 && (n1 == 0 || n2 * d1 > n1 * d2)) begin
      cn = n2;
      cd = d2;
    end else begin
      cn = n1;
      cd = d1;
    end
    if (cn == 0) begin
      r.rate = LMAX;
      r.sat = 1'b1;
      return 1;
    end
    q = cn / cd;
    r.avg = (q > LMAX) ? LMAX : q[23:0];
    q = (cd << 24) / cn;
    r.rate = (q > LMAX) ? LMAX : q[23:0];
    return 1;
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Input driver: presents queued packets with random gaps between beats.
  int drv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        void'(pending_packets.pop_front());
        accepted++;
        drv_gap = gap_len();
        if (drv_gap == 0 && pending_packets.size() > 0) begin
          packet_lost_i <= pending_packets[0].lost;
          report_i <= pending_packets[0].report;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_packets.size() > 0) begin
          in_valid_i <= 1'b1;
          packet_lost_i <= pending_packets[0].lost;
          report_i <= pending_packets[0].report;
        end
      end
    end
  end

  // Model update on every accepted input beat.
  always @(posedge clk_i) begin
    estimate_t r;
    packet_t p;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      p.lost = packet_lost_i;
      p.report = report_i;
      if (estimate_step(p, r)) expected_estimates.push_back(r);
    end
  end

  // Result monitor with random output stalls.
  int stall_left = 0;
  always @(posedge clk_i) begin
    estimate_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_estimates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected estimate rate=%0d avg=%0d sat=%0b",
                                         loss_event_rate_o, average_interval_o, saturated_o);
        end else begin
          exp_r = expected_estimates.pop_front();
          if (exp_r.rate !== loss_event_rate_o || exp_r.avg !== average_interval_o ||
              exp_r.sat !== saturated_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("estimate mismatch: expected rate=%0d avg=%0d sat=%0b, got %0d %0d %0b",
                       exp_r.rate, exp_r.avg, exp_r.sat, loss_event_rate_o,
                       average_interval_o, saturated_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = gap_len();
        out_stall_i <= (stall_left > 0);
      end
    end
  end

  task automatic wait_idle();
    while (pending_packets.size() > 0 || in_valid_i || expected_estimates.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SMOOTH) begin
      m_smooth = val[0];
      rebuild_weights();
    end else if (idx == REG_DISCOUNT) begin
      m_disc_en = val[0];
    end else begin
      m_min_ratio = val;
    end
  endtask

  task automatic queue_packet(input logic lost, input logic rep);
    packet_t p;
    p.lost = lost;
    p.report = rep;
    pending_packets.push_back(p);
  endtask

  // Random traffic: mostly runs of received packets ended by a loss.
  task automatic random_phase(input int items);
    int run;
    int made;
    made = 0;
    while (made < items) begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      for (int i = 0; i < run && made < items; i++) begin
        queue_packet(1'b0, $urandom_range(0, 3) == 0);
        made++;
      end
      queue_packet(1'b1, $urandom_range(0, 2) == 0);
      made++;
    end
  endtask

  initial begin
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a report before any loss, back-to-back losses, an interval of eight packets, then a report.
    queue_packet(1'b0, 1'b1);
    queue_packet(1'b1, 1'b1);
    queue_packet(1'b1, 1'b1);
    queue_packet(1'b1, 1'b0);
    for (int i = 0; i < 8; i++) queue_packet(1'b0, 1'b0);
    queue_packet(1'b1, 1'b1);
    for (int i = 0; i < 10; i++) queue_packet(1'b1, i[0]);
    queue_packet(1'b0, 1'b1);
    wait_idle();

    // Settings sweep, including extremes of the clamp and both history modes.
    write_reg(REG_SMOOTH, 16'd1);
    write_reg(REG_MIN_RATIO, 16'd0);
    random_phase(90);
    wait_idle();
    write_reg(REG_MIN_RATIO, 16'hFFFF);
    random_phase(90);
    wait_idle();
    write_reg(REG_DISCOUNT, 16'd0);
    write_reg(REG_SMOOTH, 16'd0);
    random_phase(90);
    wait_idle();
    write_reg(REG_DISCOUNT, 16'd1);
    write_reg(REG_MIN_RATIO, 16'(($urandom_range(0, 65535))));
    random_phase(90);
    wait_idle();
    write_reg(REG_SMOOTH, 16'd1);
    write_reg(REG_MIN_RATIO, 16'h5555);
    random_phase(90);
    wait_idle();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
